### hdl/fms_pkg.sv
// fms_pkg: shared types, constants and arithmetic helpers of the fourier mode force sum
// no dependencies; used by fms_front, fms_back and fourier_mode_force_sum
package fms_pkg;

  localparam int QDEPTH = 2;

  // odd taylor coefficients of sin(pi/2 v), q30
  localparam logic signed [31:0] K1 = 32'sd1686629713;
  localparam logic signed [31:0] K3 = 32'sd693598668;
  localparam logic signed [31:0] K5 = 32'sd85569306;
  localparam logic signed [31:0] K7 = 32'sd5026995;
  localparam logic signed [31:0] K9 = 32'sd172272;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;

  typedef enum logic [1:0] {
    QD_0 = 2'd0,
    QD_1 = 2'd1,
    QD_2 = 2'd2,
    QD_3 = 2'd3
  } quad_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic signed [31:0] iz;
  } amp_t;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    amp_t               amp;
  } mode_t;

  typedef struct packed {
    logic               is_eval;
    logic               wr_ok;
    logic [7:0]         idx;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    amp_t               amp;
  } req_t;

  // (t * v) >> 30 rounded toward zero, v in [0, 2^30]
  function automatic logic signed [31:0] mul_q30(logic signed [31:0] t, logic [30:0] v);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] p;
    a = 64'(t);
    b = {33'd0, v};
    p = a * b;
    if (p < 0) begin
      p = p + 64'sd1073741823;
    end
    return 32'(p >>> 30);
  endfunction

  // one horner step: k + (t * v2) >> 30
  function automatic logic signed [31:0] hstep(logic signed [31:0] t, logic [30:0] v2,
                                               logic signed [31:0] k);
    return k + mul_q30(t, v2);
  endfunction

  // final multiply by v, clamp to [0, 1], round to q16
  function automatic logic [16:0] sine_q16(logic signed [31:0] t, logic [30:0] v);
    logic signed [31:0] s;
    logic [31:0]        r;
    s = mul_q30(t, v);
    if (s < 0) begin
      s = 32'sd0;
    end
    if (s > $signed({1'b0, Q30_ONE})) begin
      s = $signed({1'b0, Q30_ONE});
    end
    r = (32'(s) + 32'd8192) >> 14;
    return r[16:0];
  endfunction

endpackage

### hdl/fms_front.sv
// fms_front: accepts input items, classifies them and holds them in a short queue
// depends on fms_pkg
module fms_front #(
  parameter int MAX_MODES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [7:0]          mode_index,
  input  logic signed [31:0]  vec_x,
  input  logic signed [31:0]  vec_y,
  input  logic signed [31:0]  vec_z,
  input  logic signed [31:0]  amp_real_x,
  input  logic signed [31:0]  amp_real_y,
  input  logic signed [31:0]  amp_real_z,
  input  logic signed [31:0]  amp_imag_x,
  input  logic signed [31:0]  amp_imag_y,
  input  logic signed [31:0]  amp_imag_z,
  output logic                q_valid,
  output fms_pkg::req_t       q_item,
  input  logic                q_pop
);

  fms_pkg::req_t slot [fms_pkg::QDEPTH];
  fms_pkg::req_t item;
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;

  assign in_ready = (cnt != 2'(fms_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slot[rp];

  always_comb begin
    item.is_eval = req_type;
    item.wr_ok   = !req_type && (32'(mode_index) < MAX_MODES);
    item.idx     = mode_index;
    item.vx      = vec_x;
    item.vy      = vec_y;
    item.vz      = vec_z;
    item.amp.rx  = amp_real_x;
    item.amp.ry  = amp_real_y;
    item.amp.rz  = amp_real_z;
    item.amp.ix  = amp_imag_x;
    item.amp.iy  = amp_imag_y;
    item.amp.iz  = amp_imag_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop && q_valid) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

### hdl/fms_back.sv
// fms_back: mode table, per-mode evaluation pipeline, accumulator and output register
// depends on fms_pkg
module fms_back #(
  parameter int MAX_MODES  = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [8:0]         mode_count,
  input  logic               q_valid,
  input  fms_pkg::req_t      q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z
);

  localparam int AW  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CW  = $clog2(MAX_MODES + 1);
  localparam int NST = 11;

  fms_pkg::mode_t  mem [MAX_MODES];
  fms_pkg::state_t state;
  logic [CW-1:0]   j;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   lim_next;
  logic            issue;
  logic            done_fire;
  logic [NST:1]    pvld;

  logic signed [31:0] px, py, pz;

  // pipeline registers
  fms_pkg::mode_t     mrd;
  fms_pkg::amp_t      amp_d [2:9];
  logic signed [63:0] phx, phy, phz;
  logic [1:0]         q_d [3:9];
  logic [30:0]        u_d [3:8];
  logic [30:0]        w_d [3:8];
  logic [30:0]        v2u [4:7];
  logic [30:0]        v2w [4:7];
  logic signed [31:0] tu [5:8];
  logic signed [31:0] tw [5:8];
  logic [16:0]        su, sw;
  logic signed [49:0] prx, pry, prz, pix, piy, piz;
  logic signed [42:0] trx, try_, trz;
  logic signed [47:0] acc_x, acc_y, acc_z;

  logic [63:0]           ph_sum;
  logic [ANGLE_BITS-1:0] ang;
  logic [29:0]           u30;
  logic [61:0]           squ, sqw;
  logic signed [17:0]    sn, cs;

  assign q_pop     = (state == fms_pkg::ST_IDLE) && q_valid;
  assign issue     = (state == fms_pkg::ST_RUN);
  assign done_fire = (state == fms_pkg::ST_DONE) && (!out_valid || out_ready);
  assign lim_next  = (32'(mode_count) > MAX_MODES) ? CW'(MAX_MODES) : CW'(mode_count);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fms_pkg::ST_IDLE;
      j         <= '0;
      lim       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        fms_pkg::ST_IDLE: begin
          if (q_pop && q_item.is_eval) begin
            j   <= '0;
            lim <= lim_next;
            state <= (lim_next == '0) ? fms_pkg::ST_DONE : fms_pkg::ST_RUN;
          end
        end
        fms_pkg::ST_RUN: begin
          j <= j + CW'(1);
          if (j == lim - CW'(1)) begin
            state <= fms_pkg::ST_DRAIN;
          end
        end
        fms_pkg::ST_DRAIN: begin
          if (pvld == '0) begin
            state <= fms_pkg::ST_DONE;
          end
        end
        fms_pkg::ST_DONE: begin
          if (done_fire) begin
            state <= fms_pkg::ST_IDLE;
          end
        end
        default: state <= fms_pkg::ST_IDLE;
      endcase
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= '0;
    end else begin
      pvld <= {pvld[NST-1:1], issue};
    end
  end

  // mode table
  always_ff @(posedge clk) begin
    if (q_pop && q_item.wr_ok) begin
      mem[AW'(q_item.idx)] <= '{wx: q_item.vx, wy: q_item.vy, wz: q_item.vz,
                                amp: q_item.amp};
    end
    if (issue) begin
      mrd <= mem[j[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_eval) begin
      px <= q_item.vx;
      py <= q_item.vy;
      pz <= q_item.vz;
    end
  end

  always_comb begin
    ph_sum = phx + phy + phz;
    ang    = ph_sum[39 -: ANGLE_BITS];
    u30    = {ang[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
    squ    = u_d[3] * u_d[3];
    sqw    = w_d[3] * w_d[3];
    case (fms_pkg::quad_t'(q_d[9]))
      fms_pkg::QD_0: begin
        sn = 18'(su);
        cs = 18'(sw);
      end
      fms_pkg::QD_1: begin
        sn = 18'(sw);
        cs = -18'(su);
      end
      fms_pkg::QD_2: begin
        sn = -18'(su);
        cs = -18'(sw);
      end
      default: begin
        sn = -18'(sw);
        cs = 18'(su);
      end
    endcase
  end

  // evaluation pipeline, one mode per cycle
  always_ff @(posedge clk) begin
    amp_d[2] <= mrd.amp;
    for (int s = 3; s <= 9; s++) begin
      amp_d[s] <= amp_d[s-1];
    end
    phx <= 64'(mrd.wx) * 64'(px);
    phy <= 64'(mrd.wy) * 64'(py);
    phz <= 64'(mrd.wz) * 64'(pz);

    q_d[3] <= ang[ANGLE_BITS-1 -: 2];
    u_d[3] <= {1'b0, u30};
    w_d[3] <= fms_pkg::Q30_ONE - {1'b0, u30};
    for (int s = 4; s <= 9; s++) begin
      q_d[s] <= q_d[s-1];
    end
    for (int s = 4; s <= 8; s++) begin
      u_d[s] <= u_d[s-1];
      w_d[s] <= w_d[s-1];
    end

    v2u[4] <= 31'(squ >> 30);
    v2w[4] <= 31'(sqw >> 30);
    for (int s = 5; s <= 7; s++) begin
      v2u[s] <= v2u[s-1];
      v2w[s] <= v2w[s-1];
    end

    tu[5] <= fms_pkg::hstep(fms_pkg::K9, v2u[4], -fms_pkg::K7);
    tw[5] <= fms_pkg::hstep(fms_pkg::K9, v2w[4], -fms_pkg::K7);
    tu[6] <= fms_pkg::hstep(tu[5], v2u[5], fms_pkg::K5);
    tw[6] <= fms_pkg::hstep(tw[5], v2w[5], fms_pkg::K5);
    tu[7] <= fms_pkg::hstep(tu[6], v2u[6], -fms_pkg::K3);
    tw[7] <= fms_pkg::hstep(tw[6], v2w[6], -fms_pkg::K3);
    tu[8] <= fms_pkg::hstep(tu[7], v2u[7], fms_pkg::K1);
    tw[8] <= fms_pkg::hstep(tw[7], v2w[7], fms_pkg::K1);

    su <= fms_pkg::sine_q16(tu[8], u_d[8]);
    sw <= fms_pkg::sine_q16(tw[8], w_d[8]);

    prx <= 50'(amp_d[9].rx) * 50'(cs);
    pry <= 50'(amp_d[9].ry) * 50'(cs);
    prz <= 50'(amp_d[9].rz) * 50'(cs);
    pix <= 50'(amp_d[9].ix) * 50'(sn);
    piy <= 50'(amp_d[9].iy) * 50'(sn);
    piz <= 50'(amp_d[9].iz) * 50'(sn);

    trx  <= 43'((51'(prx) - 51'(pix)) >>> 8);
    try_ <= 43'((51'(pry) - 51'(piy)) >>> 8);
    trz  <= 43'((51'(prz) - 51'(piz)) >>> 8);
  end

  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                 logic signed [42:0] t);
    logic signed [49:0] r;
    r = 50'(a) + 50'(t);
    if (r > fms_pkg::ACC_MAX) begin
      r = fms_pkg::ACC_MAX;
    end
    if (r < fms_pkg::ACC_MIN) begin
      r = fms_pkg::ACC_MIN;
    end
    return 48'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_eval) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (pvld[NST]) begin
      acc_x <= sat_add(acc_x, trx);
      acc_y <= sat_add(acc_y, try_);
      acc_z <= sat_add(acc_z, trz);
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      force_x <= acc_x;
      force_y <= acc_y;
      force_z <= acc_z;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == fms_pkg::ST_IDLE) |-> (pvld == '0))
    else $error("pipeline busy while idle");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == fms_pkg::ST_DONE))
    else $error("result raised outside done");

  a_no_acc_in_done: assert property (@(posedge clk) disable iff (rst)
    (state == fms_pkg::ST_DONE) |-> !pvld[NST])
    else $error("term added after drain");

endmodule

### hdl/fourier_mode_force_sum.sv
// fourier_mode_force_sum: top level, config register and front/back hookup
// depends on fms_pkg, fms_front, fms_back
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | req_type, mode_index, vec_*, amp_real_*, amp_imag_*
//  out     | out_valid / out_ready | force_x, force_y, force_z
//  cfg     | cfg_we                | cfg_wdata (mode_count)
//
// a load item with an index below MAX_MODES is written to the mode table when it is popped; an evaluate sweeps
// min(mode_count, MAX_MODES) modes (none when the count is zero) through the
// one-mode-per-cycle table read feeding the sine/cosine pipeline
// a two-entry queue lets input transfers continue while the back end works
// and while a result waits in the output register
// rst is synchronous; it empties the queue and pipeline, mode_count returns to 1
// the mode table has no reset and must be loaded before it is read
module fourier_mode_force_sum #(
  parameter int MAX_MODES  = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         mode_index,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] amp_real_x,
  input  logic signed [31:0] amp_real_y,
  input  logic signed [31:0] amp_real_z,
  input  logic signed [31:0] amp_imag_x,
  input  logic signed [31:0] amp_imag_y,
  input  logic signed [31:0] amp_imag_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z
);

  logic [8:0]    mode_count;
  logic          q_valid;
  logic          q_pop;
  fms_pkg::req_t q_item;

  // modes summed per evaluate
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count <= 9'd1;
    end else if (cfg_we) begin
      mode_count <= cfg_wdata;
    end
  end

  // front: classify and queue
  fms_front #(
    .MAX_MODES (MAX_MODES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .mode_index (mode_index),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .amp_real_x (amp_real_x),
    .amp_real_y (amp_real_y),
    .amp_real_z (amp_real_z),
    .amp_imag_x (amp_imag_x),
    .amp_imag_y (amp_imag_y),
    .amp_imag_z (amp_imag_z),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: table writes, mode sweep, accumulate, result register
  fms_back #(
    .MAX_MODES  (MAX_MODES),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .mode_count (mode_count),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .force_x    (force_x),
    .force_y    (force_y),
    .force_z    (force_z)
  );

endmodule
